// File: rtl/acwc_pkg.sv
// ----------------------------------------------------------------------------
// acwc_pkg
// Types and constants shared by the alarm clock with countdown.
// ----------------------------------------------------------------------------
package acwc_pkg;

   localparam int HOUR_W  = 5;
   localparam int MS_W    = 6;
   localparam int KIND_W  = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;

   localparam logic [HOUR_W-1:0] MAX_HOUR = HOUR_W'(23);
   localparam logic [MS_W-1:0]   MAX_MS   = MS_W'(59);

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK         = 3'd0,
      KIND_SET_TIME     = 3'd1,
      KIND_START_CD     = 3'd2,
      KIND_TOGGLE_ALARM = 3'd3,
      KIND_DISMISS_ALARM = 3'd4,
      KIND_DISMISS_CD   = 3'd5
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALARM_HOUR   = 1'b0,
      CSR_ALARM_MINUTE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [HOUR_W-1:0] value_hour;
      logic [MS_W-1:0]   value_minute;
      logic [MS_W-1:0]   value_second;
   } req_type;

   typedef struct packed {
      logic [HOUR_W-1:0] now_hour;
      logic [MS_W-1:0]   now_minute;
      logic [MS_W-1:0]   now_second;
      logic              alarm_armed;
      logic              alarm_ringing;
      logic [HOUR_W-1:0] left_hour;
      logic [MS_W-1:0]   left_minute;
      logic [MS_W-1:0]   left_second;
      logic              countdown_running;
      logic              countdown_done;
   } rsp_type;

endpackage

// File: rtl/acwc_req_if.sv
// ----------------------------------------------------------------------------
// acwc_req_if
// Request channel: one event beat with its time value.
// ----------------------------------------------------------------------------
interface acwc_req_if
   import acwc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [HOUR_W-1:0] value_hour;
   logic [MS_W-1:0]   value_minute;
   logic [MS_W-1:0]   value_second;

   modport source (output valid, kind, value_hour, value_minute, value_second,
                   input ready);
   modport sink   (input valid, kind, value_hour, value_minute, value_second,
                   output ready);
endinterface

// File: rtl/acwc_rsp_if.sv
// ----------------------------------------------------------------------------
// acwc_rsp_if
// Response channel: full clock, alarm and countdown state after an event.
// ----------------------------------------------------------------------------
interface acwc_rsp_if
   import acwc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [HOUR_W-1:0] now_hour;
   logic [MS_W-1:0]   now_minute;
   logic [MS_W-1:0]   now_second;
   logic              alarm_armed;
   logic              alarm_ringing;
   logic [HOUR_W-1:0] left_hour;
   logic [MS_W-1:0]   left_minute;
   logic [MS_W-1:0]   left_second;
   logic              countdown_running;
   logic              countdown_done;

   modport source (output valid, now_hour, now_minute, now_second, alarm_armed,
                   alarm_ringing, left_hour, left_minute, left_second,
                   countdown_running, countdown_done,
                   input ready);
   modport sink   (input valid, now_hour, now_minute, now_second, alarm_armed,
                   alarm_ringing, left_hour, left_minute, left_second,
                   countdown_running, countdown_done,
                   output ready);
endinterface

// File: rtl/alarm_clock_with_countdown.sv
// ----------------------------------------------------------------------------
// alarm_clock_with_countdown
// 24-hour clock with alarm and countdown timer, one event per beat.
//
//   channel   dir   handshake        payload
//   req_bus   in    valid / ready    kind, value_hour/minute/second
//   rsp_bus   out   valid / ready    clock, alarm flags, countdown, flags
//   csr_*     in    csr_we           csr_index, csr_wdata (alarm hour/minute)
//
// One beat per cycle sustained while rsp_bus.ready is high; the input register
// feeds the event update into the result register.
// Reset (synchronous) zeroes clock, countdown, flags and alarm registers.
// A stalled result holds; the input register still takes one more beat if it is empty.
// ----------------------------------------------------------------------------
module alarm_clock_with_countdown
   import acwc_pkg::*;
   (
   input  logic                  clock,
   input  logic                  reset,
   acwc_req_if.sink              req_bus,
   acwc_rsp_if.source            rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
   );

   logic              req_valid_ff;
   req_type           req_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   rsp_type           state_ff;
   rsp_type           state_in;
   logic [HOUR_W-1:0] alarm_hour_ff;
   logic [MS_W-1:0]   alarm_minute_ff;
   logic              advance;
   logic              cd_zero;
   logic [HOUR_W-1:0] sat_hour;
   logic [MS_W-1:0]   sat_minute;
   logic [MS_W-1:0]   sat_second;

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !req_valid_ff || advance;

   assign sat_hour   = (req_ff.value_hour > MAX_HOUR) ? MAX_HOUR : req_ff.value_hour;
   assign sat_minute = (req_ff.value_minute > MAX_MS) ? MAX_MS : req_ff.value_minute;
   assign sat_second = (req_ff.value_second > MAX_MS) ? MAX_MS : req_ff.value_second;

   always_comb begin
      state_in = state_ff;
      cd_zero  = 1'b0;
      case (kind_type'(req_ff.kind))
         KIND_TICK: begin
            if (state_ff.now_second == MAX_MS) begin
               state_in.now_second = '0;
               if (state_ff.now_minute == MAX_MS) begin
                  state_in.now_minute = '0;
                  state_in.now_hour = (state_ff.now_hour >= MAX_HOUR) ? '0
                                      : state_ff.now_hour + HOUR_W'(1);
               end else begin
                  state_in.now_minute = state_ff.now_minute + MS_W'(1);
               end
            end else begin
               state_in.now_second = state_ff.now_second + MS_W'(1);
            end
            if (state_ff.countdown_running) begin
               if (state_ff.left_second != '0) begin
                  state_in.left_second = state_ff.left_second - MS_W'(1);
               end else if (state_ff.left_minute != '0) begin
                  state_in.left_minute = state_ff.left_minute - MS_W'(1);
                  state_in.left_second = MAX_MS;
               end else if (state_ff.left_hour != '0) begin
                  state_in.left_hour   = state_ff.left_hour - HOUR_W'(1);
                  state_in.left_minute = MAX_MS;
                  state_in.left_second = MAX_MS;
               end
               cd_zero = (state_in.left_hour == '0) && (state_in.left_minute == '0)
                         && (state_in.left_second == '0);
            end
         end
         KIND_SET_TIME: begin
            state_in.now_hour   = sat_hour;
            state_in.now_minute = sat_minute;
            state_in.now_second = sat_second;
         end
         KIND_START_CD: begin
            state_in.left_hour         = sat_hour;
            state_in.left_minute       = sat_minute;
            state_in.left_second       = sat_second;
            state_in.countdown_running = 1'b1;
            state_in.countdown_done    = 1'b0;
            cd_zero = (sat_hour == '0) && (sat_minute == '0) && (sat_second == '0);
         end
         KIND_TOGGLE_ALARM: begin
            state_in.alarm_armed = !state_ff.alarm_armed;
         end
         KIND_DISMISS_ALARM: begin
            state_in.alarm_armed   = 1'b0;
            state_in.alarm_ringing = 1'b0;
         end
         KIND_DISMISS_CD: begin
            state_in.countdown_running = 1'b0;
            state_in.countdown_done    = 1'b0;
         end
         default: begin
         end
      endcase
      if (cd_zero) begin
         state_in.countdown_running = 1'b0;
         state_in.countdown_done    = 1'b1;
      end
      if (state_in.alarm_armed && (state_in.now_hour == alarm_hour_ff)
          && (state_in.now_minute == alarm_minute_ff)) begin
         state_in.alarm_ringing = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         state_ff        <= '0;
         alarm_hour_ff   <= '0;
         alarm_minute_ff <= '0;
      end else begin
         if (req_bus.ready) begin
            req_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            rsp_valid_ff <= req_valid_ff;
            if (req_valid_ff) begin
               state_ff <= state_in;
            end
         end
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_ALARM_HOUR:   alarm_hour_ff   <= csr_wdata[HOUR_W-1:0];
               CSR_ALARM_MINUTE: alarm_minute_ff <= csr_wdata[MS_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         req_ff.kind         <= req_bus.kind;
         req_ff.value_hour   <= req_bus.value_hour;
         req_ff.value_minute <= req_bus.value_minute;
         req_ff.value_second <= req_bus.value_second;
      end
      if (advance && req_valid_ff) begin
         rsp_ff <= state_in;
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.now_hour          = rsp_ff.now_hour;
   assign rsp_bus.now_minute        = rsp_ff.now_minute;
   assign rsp_bus.now_second        = rsp_ff.now_second;
   assign rsp_bus.alarm_armed       = rsp_ff.alarm_armed;
   assign rsp_bus.alarm_ringing     = rsp_ff.alarm_ringing;
   assign rsp_bus.left_hour         = rsp_ff.left_hour;
   assign rsp_bus.left_minute       = rsp_ff.left_minute;
   assign rsp_bus.left_second       = rsp_ff.left_second;
   assign rsp_bus.countdown_running = rsp_ff.countdown_running;
   assign rsp_bus.countdown_done    = rsp_ff.countdown_done;

endmodule

// File: rtl/acwc_checker.sv
// ----------------------------------------------------------------------------
// acwc_checker
// Port-level checks on the response channel of the alarm clock.
// ----------------------------------------------------------------------------
module acwc_checker
   import acwc_pkg::*;
   (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [HOUR_W-1:0] now_hour,
   input logic [MS_W-1:0]   now_minute,
   input logic [MS_W-1:0]   now_second,
   input logic [HOUR_W-1:0] left_hour,
   input logic [MS_W-1:0]   left_minute,
   input logic [MS_W-1:0]   left_second,
   input logic              countdown_running,
   input logic              countdown_done
   );

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (now_hour <= MAX_HOUR) && (now_minute <= MAX_MS)
                    && (now_second <= MAX_MS) && (left_hour <= MAX_HOUR)
                    && (left_minute <= MAX_MS) && (left_second <= MAX_MS))
      else $error("time field out of range");

   a_run_xor_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(countdown_running && countdown_done))
      else $error("countdown running and done together");

   a_running_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && countdown_running |->
         (left_hour != '0) || (left_minute != '0) || (left_second != '0))
      else $error("countdown running at zero");

endmodule

bind alarm_clock_with_countdown acwc_checker u_acwc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .now_hour          (rsp_bus.now_hour),
   .now_minute        (rsp_bus.now_minute),
   .now_second        (rsp_bus.now_second),
   .left_hour         (rsp_bus.left_hour),
   .left_minute       (rsp_bus.left_minute),
   .left_second       (rsp_bus.left_second),
   .countdown_running (rsp_bus.countdown_running),
   .countdown_done    (rsp_bus.countdown_done)
);
